[rtl/wsfp_pkg.sv]
`default_nettype none

package wsfp_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Seven-bit length codes that announce an extended length field.
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Header bytes that follow for each extension and for the mask key.
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // Limit after reset: 1 GiB.
  localparam logic [30:0] MAX_LEN_RESET = 31'h4000_0000;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_flags;
    logic [30:0] payload_length;
    logic        was_masked;
    logic        last_of_frame;
  } result_t;

endpackage

`default_nettype wire

[rtl/wsfp_if.sv]
`default_nettype none

// Byte stream channel into the parser.
interface wsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// Result channel out of the parser.
interface wsfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  data_byte;
  logic [7:0]  frame_flags;
  logic [30:0] payload_length;
  logic        was_masked;
  logic        last_of_frame;

  modport source (output valid, output result_kind, output data_byte, output frame_flags,
                  output payload_length, output was_masked, output last_of_frame,
                  input ready);
  modport sink   (input valid, input result_kind, input data_byte, input frame_flags,
                  input payload_length, input was_masked, input last_of_frame,
                  output ready);
endinterface

`default_nettype wire

[rtl/websocket_frame_parser.sv]
// Channel   Direction  Payload                                       Handshake
// stream    in         in_byte                                       valid/ready
// result    out        result_kind, data_byte, frame_flags,          valid/ready
//                      payload_length, was_masked, last_of_frame
// cfg       in         cfg_wdata (max_payload_length)                cfg_we
//
// One byte is taken per cycle while no result is stalled; its result, if any, shows on
// the result channel in the next cycle. The rate is set by the single output register.
// Reset is synchronous and active high; it clears the parser and sets the limit to 1 GiB.
// A stalled result holds the output register; a new byte is still taken in the cycle
// that the held result leaves.
`default_nettype none

module websocket_frame_parser
  import wsfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  wsfp_in_if.sink          stream,
  wsfp_out_if.source       result,
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_wdata
);

  logic    space;
  logic    accept;
  logic    res_valid;
  result_t res;

  // The input is ready whenever the output register can take the item's result,
  // so a byte that gives no result and a byte that gives one are treated alike.
  assign stream.ready = space;
  assign accept       = stream.valid && space;

  // Header parsing, length check, unmasking and the sticky error all live in the
  // parser; it computes the result of the accepted byte in the same cycle.
  wsfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (stream.in_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  // The output register separates the parser from a stalling consumer.
  wsfp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_data (res),
    .space     (space),
    .result    (result)
  );

endmodule

`default_nettype wire

[rtl/wsfp_parser.sv]
`default_nettype none

module wsfp_parser
  import wsfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  in_byte,
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_wdata,
  output logic             res_valid,
  output result_t          res
);

  typedef enum logic [2:0] {
    PH_FLAGS,
    PH_LEN7,
    PH_EXTLEN,
    PH_MASKKEY,
    PH_PAYLOAD
  } phase_t;

  phase_t            phase, phase_next;
  logic [3:0]        hdr_left, hdr_left_next;
  logic [7:0]        flags, flags_next;
  logic              masked, masked_next;
  logic [63:0]       acc, acc_next;
  logic [3:0][7:0]   key, key_next;
  logic [30:0]       pay_left, pay_left_next;
  logic [1:0]        pos, pos_next;
  logic              err, err_next;
  logic [30:0]       max_len;

  logic              finish;
  logic              fire;
  logic              oversize;
  logic [7:0]        key_byte;

  // The whole decoded length counts, including the bits above the limit's width.
  assign oversize = (acc_next[63:31] != '0) || (acc_next[30:0] > max_len);
  // Key bytes go out first byte first; the first one sits in the top lane.
  assign key_byte = masked ? key[~pos] : 8'h00;

  always_comb begin
    phase_next    = phase;
    hdr_left_next = hdr_left;
    flags_next    = flags;
    masked_next   = masked;
    acc_next      = acc;
    key_next      = key;
    pay_left_next = pay_left;
    pos_next      = pos;
    err_next      = err;
    finish        = 1'b0;
    fire          = 1'b0;
    res           = '0;

    if (accept && !err) begin
      unique case (phase)
        PH_FLAGS: begin
          flags_next  = in_byte;
          masked_next = 1'b0;
          acc_next    = '0;
          key_next    = '0;
          phase_next  = PH_LEN7;
        end
        PH_LEN7: begin
          masked_next = in_byte[7];
          if (in_byte[6:0] == LEN7_EXT16 || in_byte[6:0] == LEN7_EXT64) begin
            acc_next      = '0;
            hdr_left_next = (in_byte[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            phase_next    = PH_EXTLEN;
          end else begin
            acc_next = {57'd0, in_byte[6:0]};
            if (in_byte[7]) begin
              phase_next    = PH_MASKKEY;
              hdr_left_next = KEY_BYTES;
            end else begin
              finish = 1'b1;
            end
          end
        end
        PH_EXTLEN: begin
          acc_next      = {acc[55:0], in_byte};
          hdr_left_next = hdr_left - 4'd1;
          if (hdr_left_next == '0) begin
            if (masked) begin
              phase_next    = PH_MASKKEY;
              hdr_left_next = KEY_BYTES;
            end else begin
              finish = 1'b1;
            end
          end
        end
        PH_MASKKEY: begin
          key_next      = {key[2:0], in_byte};
          hdr_left_next = hdr_left - 4'd1;
          if (hdr_left_next == '0) begin
            finish = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          pos_next           = pos + 2'd1;
          pay_left_next      = pay_left - 31'd1;
          fire               = 1'b1;
          res.result_kind    = KIND_PAYLOAD;
          res.data_byte      = in_byte ^ key_byte;
          res.last_of_frame  = (pay_left_next == '0);
          if (pay_left_next == '0) begin
            phase_next = PH_FLAGS;
          end
        end
        default: begin
          phase_next = PH_FLAGS;
        end
      endcase

      if (finish) begin
        fire = 1'b1;
        if (oversize) begin
          err_next        = 1'b1;
          res.result_kind = KIND_ERROR;
        end else begin
          pay_left_next      = acc_next[30:0];
          pos_next           = '0;
          res.result_kind    = KIND_HEADER;
          res.payload_length = acc_next[30:0];
          res.last_of_frame  = (acc_next[30:0] == '0);
          phase_next         = (acc_next[30:0] == '0) ? PH_FLAGS : PH_PAYLOAD;
        end
      end
    end

    res.frame_flags = flags_next;
    res.was_masked  = masked_next;
  end

  assign res_valid = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_FLAGS;
      hdr_left <= '0;
      flags    <= '0;
      masked   <= 1'b0;
      acc      <= '0;
      key      <= '0;
      pay_left <= '0;
      pos      <= '0;
      err      <= 1'b0;
      max_len  <= MAX_LEN_RESET;
    end else begin
      phase    <= phase_next;
      hdr_left <= hdr_left_next;
      flags    <= flags_next;
      masked   <= masked_next;
      acc      <= acc_next;
      key      <= key_next;
      pay_left <= pay_left_next;
      pos      <= pos_next;
      err      <= err_next;
      if (cfg_we) begin
        max_len <= cfg_wdata;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/wsfp_out_reg.sv]
`default_nettype none

module wsfp_out_reg
  import wsfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_data,
  output logic         space,
  wsfp_out_if.source   result
);

  logic    full;
  result_t data;

  // Room for a new item when empty or when the held one leaves this cycle.
  assign space = !full || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (result.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

  assign result.valid          = full;
  assign result.result_kind    = data.result_kind;
  assign result.data_byte      = data.data_byte;
  assign result.frame_flags    = data.frame_flags;
  assign result.payload_length = data.payload_length;
  assign result.was_masked     = data.was_masked;
  assign result.last_of_frame  = data.last_of_frame;

endmodule

`default_nettype wire

[rtl/wsfp_checker.sv]
`default_nettype none

module wsfp_checker
  import wsfp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [7:0]  out_data,
  input wire logic [30:0] out_len,
  input wire logic        out_last
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_data) && $stable(out_len))
    else $error("result payload changed while stalled");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready with empty output");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind == KIND_HEADER || out_kind == KIND_PAYLOAD ||
                   out_kind == KIND_ERROR))
    else $error("undefined result kind");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_ERROR |-> out_len == '0 && !out_last && out_data == '0)
    else $error("error result carries data");

endmodule

bind websocket_frame_parser wsfp_checker u_wsfp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (stream.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_kind  (result.result_kind),
  .out_data  (result.data_byte),
  .out_len   (result.payload_length),
  .out_last  (result.last_of_frame)
);

`default_nettype wire
